>>> design/bit_pkg.sv
// ----------------------------------------------------------------------------
// Binary image thinning package
// Shared types, constants and neighbour tables for the thinning block.
// ----------------------------------------------------------------------------
package bit_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned DIM_CFG_W   = 9;

    localparam logic [7:0]  PIX_FG      = 8'd255;
    localparam logic [7:0]  PIX_BG      = 8'd0;
    localparam logic [3:0]  NB_MIN      = 4'd2;
    localparam logic [3:0]  NB_MAX      = 4'd6;
    localparam logic [15:0] PASS_SAT    = 16'hFFFF;
    localparam logic [3:0]  NB_LAST     = 4'd9;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CP_RD,
        ST_CP_WR,
        ST_NB,
        ST_JUDGE,
        ST_SUB_END,
        ST_RUN_OUT
    } state_t;

    // Offsets (plus one) of the centre, then p2..p9 around it
    function automatic logic [1:0] nb_row_ofs(input logic [3:0] k);
        logic [1:0] o;
        unique case (k)
            4'd0:    o = 2'd1;
            4'd1:    o = 2'd0;
            4'd2:    o = 2'd0;
            4'd3:    o = 2'd1;
            4'd4:    o = 2'd2;
            4'd5:    o = 2'd2;
            4'd6:    o = 2'd2;
            4'd7:    o = 2'd1;
            4'd8:    o = 2'd0;
            default: o = 2'd1;
        endcase
        return o;
    endfunction

    function automatic logic [1:0] nb_col_ofs(input logic [3:0] k);
        logic [1:0] o;
        unique case (k)
            4'd0:    o = 2'd1;
            4'd1:    o = 2'd1;
            4'd2:    o = 2'd2;
            4'd3:    o = 2'd2;
            4'd4:    o = 2'd2;
            4'd5:    o = 2'd1;
            4'd6:    o = 2'd0;
            4'd7:    o = 2'd0;
            4'd8:    o = 2'd0;
            default: o = 2'd1;
        endcase
        return o;
    endfunction

    // Zhang-Suen deletion test; n[0..7] = p2..p9
    function automatic logic zs_delete(input logic [7:0] n, input logic phase);
        logic [7:0] tr;
        logic [3:0] a;
        logic [3:0] b;
        logic       m1;
        logic       m2;
        tr = ~n & {n[0], n[7:1]};
        a  = 4'd0;
        b  = 4'd0;
        for (int i = 0; i < 8; i++) begin
            a = a + {3'd0, tr[i]};
            b = b + {3'd0, n[i]};
        end
        if (!phase) begin
            m1 = n[0] & n[2] & n[4];
            m2 = n[2] & n[4] & n[6];
        end else begin
            m1 = n[0] & n[2] & n[6];
            m2 = n[0] & n[4] & n[6];
        end
        return (a == 4'd1) && (b >= NB_MIN) && (b <= NB_MAX) && !m1 && !m2;
    endfunction

endpackage

>>> design/binary_image_thinning.sv
// ----------------------------------------------------------------------------
// Binary image thinning
// Zhang-Suen skeletonisation over a stored bit image, driven by commands.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_*: one command per transfer (write pixel, run, read pixel).
//   Result stream m_*: one transfer per run or read, none for a write.
//   APB port: image_width at 0x0, image_height at 0x4; write only when idle.
// Timing
//   Writes stream at one per cycle while the sequencer is idle.
//   A read result is registered in the image memory read register, then in
//   the output register. A run copies the used image into the snapshot
//   memory (ST_CP_RD, then ST_CP_WR for each pixel) and then judges each
//   interior pixel with 9 single-port snapshot reads and one decision, per
//   sub-pass; two sub-passes per pass pair. The snapshot read port paces
//   the judging. s_tready is low throughout.
// Reset
//   Synchronous, active low: sequencer idle, no result pending, dimensions
//   back to 256. The pixel memories are not cleared.
// Stall
//   A finished result waits in the output register; a read or run that
//   completes while it is still held waits until it is taken.
// ----------------------------------------------------------------------------
module binary_image_thinning #(
    parameter int unsigned MAX_WIDTH  = bit_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bit_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command[1:0], row[9:2], column[17:10], pixel_in[25:18], zero fill
    input  logic [bit_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pixel_out[7:0], pass_pairs[23:8]
    output logic [bit_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bit_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bit_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bit_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_WIDTH) + AW'(c));
    endfunction

    // ---- input fields
    bit_pkg::cmd_t in_cmd;
    logic [7:0]    in_row;
    logic [7:0]    in_col;
    logic [7:0]    in_pix;
    logic          in_inside;

    assign in_cmd    = bit_pkg::cmd_t'(s_tdata[1:0]);
    assign in_row    = s_tdata[9:2];
    assign in_col    = s_tdata[17:10];
    assign in_pix    = s_tdata[25:18];
    assign in_inside = (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH);

    // ---- configuration registers
    logic [bit_pkg::DIM_CFG_W-1:0] cfg_w_reg;
    logic [bit_pkg::DIM_CFG_W-1:0] cfg_h_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= 9'd256;
            cfg_h_reg <= 9'd256;
        end else if (cfg_wr) begin
            unique case (bit_pkg::reg_idx_t'(paddr[2]))
                bit_pkg::REG_WIDTH:  cfg_w_reg <= pwdata[bit_pkg::DIM_CFG_W-1:0];
                bit_pkg::REG_HEIGHT: cfg_h_reg <= pwdata[bit_pkg::DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (bit_pkg::reg_idx_t'(paddr[2]))
            bit_pkg::REG_WIDTH:  prdata = 32'(cfg_w_reg);
            bit_pkg::REG_HEIGHT: prdata = 32'(cfg_h_reg);
            default:             prdata = '0;
        endcase
    end

    // zero acts as one, anything past the store acts as its size
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    always_comb begin
        if (cfg_w_reg == '0)                w_eff = CW'(1);
        else if (32'(cfg_w_reg) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else                                w_eff = CW'(cfg_w_reg);
        if (cfg_h_reg == '0)                 h_eff = RW'(1);
        else if (32'(cfg_h_reg) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
        else                                 h_eff = RW'(cfg_h_reg);
    end

    // ---- memories: working image and per-sub-pass snapshot
    logic          img_mem  [DEPTH];
    logic          snap_mem [DEPTH];
    logic          img_rdata_reg;
    logic          snap_rdata_reg;
    logic          img_we;
    logic [AW-1:0] img_waddr;
    logic          img_wdata;
    logic [AW-1:0] img_raddr;
    logic          snap_we;
    logic [AW-1:0] snap_waddr;
    logic [AW-1:0] snap_raddr;

    always_ff @(posedge aclk) begin
        if (img_we) img_mem[img_waddr] <= img_wdata;
        img_rdata_reg <= img_mem[img_raddr];
    end

    always_ff @(posedge aclk) begin
        if (snap_we) snap_mem[snap_waddr] <= img_rdata_reg;
        snap_rdata_reg <= snap_mem[snap_raddr];
    end

    // ---- sequencer
    bit_pkg::state_t state_reg, state_next;
    logic [RW-1:0]   r_reg, r_next;
    logic [CW-1:0]   c_reg, c_next;
    logic [RW-1:0]   h_reg, h_next;
    logic [CW-1:0]   w_reg, w_next;
    logic [3:0]      k_reg, k_next;
    logic [8:0]      nb_reg, nb_next;       // centre, then p2..p9
    logic            phase_reg, phase_next;
    logic            changed_reg, changed_next;
    logic [15:0]     pass_reg, pass_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic            rd_in_reg, rd_in_next;
    logic [bit_pkg::OUT_TDATA_W-1:0] out_reg, out_next;
    logic            out_vld_reg, out_vld_next;

    logic            interior;
    logic            out_free;
    logic [RW-1:0]   nr;
    logic [CW-1:0]   nc;

    assign interior = (h_reg >= RW'(3)) && (w_reg >= CW'(3));
    assign out_free = !out_vld_reg || m_tready;
    assign nr = RW'(r_reg + RW'(bit_pkg::nb_row_ofs(k_reg)) - RW'(1));
    assign nc = CW'(c_reg + CW'(bit_pkg::nb_col_ofs(k_reg)) - CW'(1));

    assign s_tready = (state_reg == bit_pkg::ST_IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bit_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
            phase_reg   <= 1'b0;
            changed_reg <= 1'b0;
            pass_reg    <= '0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            phase_reg   <= phase_next;
            changed_reg <= changed_next;
            pass_reg    <= pass_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg       <= r_next;
        c_reg       <= c_next;
        h_reg       <= h_next;
        w_reg       <= w_next;
        nb_reg      <= nb_next;
        rd_addr_reg <= rd_addr_next;
        rd_in_reg   <= rd_in_next;
        out_reg     <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        h_next       = h_reg;
        w_next       = w_reg;
        k_next       = k_reg;
        nb_next      = nb_reg;
        phase_next   = phase_reg;
        changed_next = changed_reg;
        pass_next    = pass_reg;
        rd_addr_next = rd_addr_reg;
        rd_in_next   = rd_in_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_tready;
        img_we       = 1'b0;
        img_waddr    = addr_of(RW'(in_row), CW'(in_col));
        img_wdata    = (in_pix == bit_pkg::PIX_FG);
        img_raddr    = addr_of(r_reg, c_reg);
        snap_we      = 1'b0;
        snap_waddr   = addr_of(r_reg, c_reg);
        snap_raddr   = addr_of(nr, nc);

        unique case (state_reg)
            bit_pkg::ST_IDLE: begin
                img_raddr = addr_of(RW'(in_row), CW'(in_col));
                if (s_tvalid) begin
                    unique case (in_cmd)
                        bit_pkg::CMD_WRITE: img_we = in_inside;
                        bit_pkg::CMD_RUN: begin
                            w_next       = w_eff;
                            h_next       = h_eff;
                            pass_next    = '0;
                            changed_next = 1'b0;
                            phase_next   = 1'b0;
                            r_next       = '0;
                            c_next       = '0;
                            if ((h_eff >= RW'(3)) && (w_eff >= CW'(3)))
                                state_next = bit_pkg::ST_CP_RD;
                            else
                                state_next = bit_pkg::ST_SUB_END;
                        end
                        bit_pkg::CMD_READ: begin
                            rd_addr_next = addr_of(RW'(in_row), CW'(in_col));
                            rd_in_next   = in_inside;
                            state_next   = bit_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            bit_pkg::ST_READ: begin
                img_raddr = rd_addr_reg;
                if (out_free) begin
                    out_vld_next = 1'b1;
                    out_next     = {16'd0, (rd_in_reg && img_rdata_reg) ?
                                    bit_pkg::PIX_FG : bit_pkg::PIX_BG};
                    state_next   = bit_pkg::ST_IDLE;
                end
            end
            bit_pkg::ST_CP_RD: begin
                state_next = bit_pkg::ST_CP_WR;
            end
            bit_pkg::ST_CP_WR: begin
                snap_we    = 1'b1;
                state_next = bit_pkg::ST_CP_RD;
                if (c_reg == CW'(w_reg - CW'(1))) begin
                    c_next = '0;
                    r_next = RW'(r_reg + RW'(1));
                    if (r_reg == RW'(h_reg - RW'(1))) begin
                        r_next     = RW'(1);
                        c_next     = CW'(1);
                        k_next     = '0;
                        state_next = bit_pkg::ST_NB;
                    end
                end else begin
                    c_next = CW'(c_reg + CW'(1));
                end
            end
            bit_pkg::ST_NB: begin
                // read issued for tap k, the previous tap lands now
                if (k_reg != 4'd0) nb_next[k_reg - 4'd1] = snap_rdata_reg;
                k_next = k_reg + 4'd1;
                if (k_reg == bit_pkg::NB_LAST) state_next = bit_pkg::ST_JUDGE;
            end
            bit_pkg::ST_JUDGE: begin
                img_waddr = addr_of(r_reg, c_reg);
                img_wdata = 1'b0;
                if (nb_reg[0] && bit_pkg::zs_delete(nb_reg[8:1], phase_reg)) begin
                    img_we       = 1'b1;
                    changed_next = 1'b1;
                end
                k_next     = '0;
                state_next = bit_pkg::ST_NB;
                if (c_reg == CW'(w_reg - CW'(2))) begin
                    c_next = CW'(1);
                    r_next = RW'(r_reg + RW'(1));
                    if (r_reg == RW'(h_reg - RW'(2))) state_next = bit_pkg::ST_SUB_END;
                end else begin
                    c_next = CW'(c_reg + CW'(1));
                end
            end
            bit_pkg::ST_SUB_END: begin
                r_next = '0;
                c_next = '0;
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    state_next = interior ? bit_pkg::ST_CP_RD : bit_pkg::ST_SUB_END;
                end else begin
                    if (pass_reg != bit_pkg::PASS_SAT) pass_next = pass_reg + 16'd1;
                    phase_next = 1'b0;
                    if (changed_reg) begin
                        changed_next = 1'b0;
                        state_next   = interior ? bit_pkg::ST_CP_RD :
                                                  bit_pkg::ST_SUB_END;
                    end else begin
                        state_next = bit_pkg::ST_RUN_OUT;
                    end
                end
            end
            bit_pkg::ST_RUN_OUT: begin
                if (out_free) begin
                    out_vld_next = 1'b1;
                    out_next     = {pass_reg, bit_pkg::PIX_BG};
                    state_next   = bit_pkg::ST_IDLE;
                end
            end
            default: state_next = bit_pkg::ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    // a finished run has always done at least one pass pair
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bit_pkg::ST_RUN_OUT) |-> (pass_reg != 16'd0))
        else $error("run result with zero pass pairs");

    // the tap counter never runs past the last neighbour
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bit_pkg::ST_NB) |-> (k_reg <= bit_pkg::NB_LAST))
        else $error("neighbour tap out of range");

    // pixels judged are interior ones only
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bit_pkg::ST_JUDGE) |->
        (r_reg >= RW'(1)) && (r_reg <= RW'(h_reg - RW'(2))) &&
        (c_reg >= CW'(1)) && (c_reg <= CW'(w_reg - CW'(2))))
        else $error("judged pixel outside interior");
`endif

endmodule

>>> bench/thinning_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Thinning result checker
// Watches the command, result and APB channels, keeps its own copy of the
// pixel image and dimensions, predicts each read and run result and compares
// it with what the block returns.
// ----------------------------------------------------------------------------
module thinning_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bit_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [bit_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bit_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bit_pkg::CFG_DATA_W-1:0]    pwdata,
    input  logic                              pready,
    output int                                mismatches,
    output int                                pending,
    output int                                runs_seen,
    output int                                reads_seen
);

    bit              pix_img  [0:255][0:255];
    bit              pix_snap [0:255][0:255];
    logic [8:0]      dim_w;
    logic [8:0]      dim_h;
    logic [23:0]     expected_q[$];

    function automatic int clamp_dim(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > 9'd256) return 256;
        return int'(v);
    endfunction

    // Full Zhang-Suen run on the local image; returns the pass pair count
    function automatic logic [15:0] thin_image();
        int         w;
        int         h;
        logic [15:0] pairs;
        bit         changed;
        bit         n [0:7];
        int         a;
        int         b;
        bit         m1;
        bit         m2;
        w = clamp_dim(dim_w);
        h = clamp_dim(dim_h);
        pairs = 16'd0;
        do begin
            changed = 1'b0;
            for (int ph = 0; ph < 2; ph++) begin
                pix_snap = pix_img;
                for (int r = 1; r + 1 < h; r++) begin
                    for (int c = 1; c + 1 < w; c++) begin
                        if (!pix_snap[r][c]) continue;
                        n[0] = pix_snap[r-1][c];
                        n[1] = pix_snap[r-1][c+1];
                        n[2] = pix_snap[r][c+1];
                        n[3] = pix_snap[r+1][c+1];
                        n[4] = pix_snap[r+1][c];
                        n[5] = pix_snap[r+1][c-1];
                        n[6] = pix_snap[r][c-1];
                        n[7] = pix_snap[r-1][c-1];
                        a = 0;
                        b = 0;
                        for (int k = 0; k < 8; k++) begin
                            b += n[k];
                            if (!n[k] && n[(k+1)%8]) a++;
                        end
                        if (ph == 0) begin
                            m1 = n[0] & n[2] & n[4];
                            m2 = n[2] & n[4] & n[6];
                        end else begin
                            m1 = n[0] & n[2] & n[6];
                            m2 = n[0] & n[4] & n[6];
                        end
                        if (a == 1 && b >= 2 && b <= 6 && !m1 && !m2) begin
                            pix_img[r][c] = 1'b0;
                            changed = 1'b1;
                        end
                    end
                end
            end
            if (pairs != bit_pkg::PASS_SAT) pairs++;
        end while (changed);
        return pairs;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        bit_pkg::cmd_t cmd;
        logic [7:0]    row;
        logic [7:0]    col;
        logic [7:0]    pin;
        logic [23:0]   exp_word;
        if (!aresetn) begin
            dim_w      = 9'd256;
            dim_h      = 9'd256;
            mismatches = 0;
            runs_seen  = 0;
            reads_seen = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (bit_pkg::reg_idx_t'(paddr[2]) == bit_pkg::REG_WIDTH)
                    dim_w = pwdata[8:0];
                else
                    dim_h = pwdata[8:0];
            end
            // result side before command side: a new command never
            // produces its result in the same cycle
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: pixel %0d pairs %0d",
                                 m_tdata[7:0], m_tdata[23:8]);
                end else begin
                    exp_word = expected_q.pop_front();
                    if (m_tdata !== exp_word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: pixel exp %0d got %0d,",
                                      " pairs exp %0d got %0d"},
                                     exp_word[7:0], m_tdata[7:0],
                                     exp_word[23:8], m_tdata[23:8]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                cmd = bit_pkg::cmd_t'(s_tdata[1:0]);
                row = s_tdata[9:2];
                col = s_tdata[17:10];
                pin = s_tdata[25:18];
                case (cmd)
                    bit_pkg::CMD_WRITE: pix_img[row][col] = (pin == bit_pkg::PIX_FG);
                    bit_pkg::CMD_READ: begin
                        expected_q.push_back({16'd0, pix_img[row][col] ?
                                              bit_pkg::PIX_FG : bit_pkg::PIX_BG});
                        reads_seen++;
                    end
                    bit_pkg::CMD_RUN: begin
                        expected_q.push_back({thin_image(), bit_pkg::PIX_BG});
                        runs_seen++;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> bench/tb_binary_image_thinning.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary image thinning testbench
// Loads images, thins them and reads them back under random stalls on both
// streams, across a range of image dimensions; a side checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_binary_image_thinning;

    localparam int CYCLE_LIMIT = 3000000;

    logic                              aclk;
    logic                              aresetn;
    // command[1:0], row[9:2], column[17:10], pixel_in[25:18], zero fill
    logic [bit_pkg::IN_TDATA_W-1:0]    s_tdata;
    logic                              s_tvalid;
    logic                              s_tready;
    // pixel_out[7:0], pass_pairs[23:8]
    logic [bit_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [bit_pkg::CFG_ADDR_W-1:0]    paddr;
    logic [bit_pkg::CFG_DATA_W-1:0]    pwdata;
    logic [bit_pkg::CFG_DATA_W-1:0]    prdata;
    logic                              pready;

    int  mismatches;
    int  pending;
    int  runs_seen;
    int  reads_seen;
    int  cycles;
    bit  calm;              // no idling on either side while set
    bit  loaded [0:255][0:255];   // pixels written so far
    int  area_w;
    int  area_h;

    binary_image_thinning i_dut (.*);

    thinning_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver back-pressure, about 30 % of cycles unless calm
    always @(negedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 30);

    // One command transfer, with a random gap ahead of it
    task automatic send_cmd(bit_pkg::cmd_t c, logic [7:0] r, logic [7:0] col,
                            logic [7:0] pin);
        while (!calm && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pin, col, r, c};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (c == bit_pkg::CMD_WRITE) loaded[r][col] = 1'b1;
    endtask

    task automatic apb_write(bit_pkg::reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sender holds off until every result is back, then lets a read settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    function automatic logic [7:0] rand_pixel();
        if ($urandom_range(1)) return bit_pkg::PIX_FG;
        return 8'($urandom_range(254));
    endfunction

    // New dimensions, then every pixel in use written
    task automatic set_area(logic [8:0] w_reg, logic [8:0] h_reg);
        drain();
        apb_write(bit_pkg::REG_WIDTH, {23'd0, w_reg});
        apb_write(bit_pkg::REG_HEIGHT, {23'd0, h_reg});
        area_w = (w_reg == 0) ? 1 : (w_reg > 256) ? 256 : w_reg;
        area_h = (h_reg == 0) ? 1 : (h_reg > 256) ? 256 : h_reg;
        for (int r = 0; r < area_h; r++)
            for (int c = 0; c < area_w; c++)
                send_cmd(bit_pkg::CMD_WRITE, 8'(r), 8'(c), rand_pixel());
    endtask

    // Mostly well-formed traffic inside the loaded area, some noise
    task automatic random_traffic(int n_items);
        int          k;
        logic [7:0]  r;
        logic [7:0]  c;
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(99);
            r = 8'($urandom_range(area_h - 1));
            c = 8'($urandom_range(area_w - 1));
            if (k < 50) begin
                if ($urandom_range(4) == 0) begin
                    r = 8'($urandom);
                    c = 8'($urandom);
                end
                send_cmd(bit_pkg::CMD_WRITE, r, c, rand_pixel());
            end else if (k < 80) begin
                // stray reads only hit pixels already loaded
                if ($urandom_range(4) == 0) begin
                    logic [7:0] rr;
                    logic [7:0] cc;
                    rr = 8'($urandom);
                    cc = 8'($urandom);
                    if (loaded[rr][cc]) begin
                        r = rr;
                        c = cc;
                    end
                end
                send_cmd(bit_pkg::CMD_READ, r, c, 8'($urandom));
            end else if (k < 88) begin
                send_cmd(bit_pkg::CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_cmd(bit_pkg::CMD_RUN, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        send_cmd(bit_pkg::CMD_RUN, 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 6; i++)
            send_cmd(bit_pkg::CMD_READ, 8'($urandom_range(area_h - 1)),
                     8'($urandom_range(area_w - 1)), 8'd0);
    endtask

    initial begin
        cycles   = 0;
        calm     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: corner addresses, odd pixel bytes, unused command
        send_cmd(bit_pkg::CMD_WRITE, 8'd255, 8'd255, bit_pkg::PIX_FG);
        send_cmd(bit_pkg::CMD_WRITE, 8'd0,   8'd255, 8'd254);
        send_cmd(bit_pkg::CMD_WRITE, 8'd255, 8'd0,   8'd1);
        send_cmd(bit_pkg::CMD_WRITE, 8'd0,   8'd0,   bit_pkg::PIX_FG);
        send_cmd(bit_pkg::CMD_NONE,  8'd255, 8'd255, 8'd255);
        send_cmd(bit_pkg::CMD_READ,  8'd255, 8'd255, 8'd0);
        send_cmd(bit_pkg::CMD_READ,  8'd0,   8'd255, 8'd0);
        send_cmd(bit_pkg::CMD_READ,  8'd255, 8'd0,   8'd0);
        send_cmd(bit_pkg::CMD_READ,  8'd0,   8'd0,   8'd0);

        // Directed: solid 3x3 block, single interior pixel stays
        drain();
        apb_write(bit_pkg::REG_WIDTH, 32'd3);
        apb_write(bit_pkg::REG_HEIGHT, 32'd3);
        area_w = 3;
        area_h = 3;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_cmd(bit_pkg::CMD_WRITE, 8'(r), 8'(c), bit_pkg::PIX_FG);
        send_cmd(bit_pkg::CMD_RUN,  8'd0, 8'd0, 8'd0);
        send_cmd(bit_pkg::CMD_READ, 8'd1, 8'd1, 8'd0);

        // Extremes: one column full height and one row full width,
        // both reached through out-of-range register values that clamp
        set_area(9'd0, 9'd511);
        random_traffic(10);
        set_area(9'd511, 9'd0);
        random_traffic(10);

        // Small random images; one phase without any idling
        for (int p = 0; p < 4; p++) begin
            drain();
            calm = (p == 2);
            set_area(9'($urandom_range(10, 2)), 9'($urandom_range(10, 2)));
            random_traffic(40);
        end
        calm = 1'b0;

        drain();
        repeat (20) @(negedge aclk);
        $display("covered %0d runs and %0d reads over several image sizes",
                 runs_seen, reads_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
